// ===== rtl/crt_pkg.sv =====
// ----------------------------------------------------------------------------
// crt_pkg
// shared types and constants for the two-moduli remainder search
// ----------------------------------------------------------------------------
package crt_pkg;

  localparam int VAL_W = 16;
  localparam int DAY_W = 32;
  localparam int CNT_W = $clog2(VAL_W + 1);

  typedef logic [VAL_W-1:0] val_t;
  typedef logic [DAY_W-1:0] day_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_SPAN,
    ST_BMOD,
    ST_TMOD,
    ST_SEARCH,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic start;
    val_t dividend;
    val_t divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    val_t quotient;
    val_t remainder;
  } div_rsp_t;

endpackage

// ===== rtl/crt_in_if.sv =====
// ----------------------------------------------------------------------------
// crt_in_if
// input channel: two moduli and two targets per transfer
// ----------------------------------------------------------------------------
interface crt_in_if;
  logic          valid;
  logic          ready;
  crt_pkg::val_t modulus_m;
  crt_pkg::val_t modulus_n;
  crt_pkg::val_t target_x;
  crt_pkg::val_t target_y;

  modport source (output valid, modulus_m, modulus_n, target_x, target_y, input ready);
  modport sink (input valid, modulus_m, modulus_n, target_x, target_y, output ready);
endinterface

// ===== rtl/crt_out_if.sv =====
// ----------------------------------------------------------------------------
// crt_out_if
// result channel: found flag and smallest matching day
// ----------------------------------------------------------------------------
interface crt_out_if;
  logic          valid;
  logic          ready;
  logic          found;
  crt_pkg::day_t day_number;

  modport source (output valid, found, day_number, input ready);
  modport sink (input valid, found, day_number, output ready);
endinterface

// ===== rtl/crt_div.sv =====
// ----------------------------------------------------------------------------
// crt_div
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module crt_div (
  input  logic              clk,
  input  logic              rst,
  input  crt_pkg::div_req_t req,
  output crt_pkg::div_rsp_t rsp
);

  logic                      busy;
  logic                      done;
  logic [crt_pkg::CNT_W-1:0] cnt;
  crt_pkg::val_t             quo;
  crt_pkg::val_t             rem;
  crt_pkg::val_t             dvs;

  logic [crt_pkg::VAL_W:0] sh;
  logic [crt_pkg::VAL_W:0] diff;
  logic                    ge;

  always_comb begin
    sh   = {rem, quo[crt_pkg::VAL_W-1]};
    ge   = sh >= {1'b0, dvs};
    diff = sh - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == crt_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (req.start) begin
        busy <= 1'b1;
        cnt  <= crt_pkg::CNT_W'(crt_pkg::VAL_W);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      rem <= ge ? diff[crt_pkg::VAL_W-1:0] : sh[crt_pkg::VAL_W-1:0];
      quo <= {quo[crt_pkg::VAL_W-2:0], ge};
    end else if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

// ===== rtl/crt_pair_search.sv =====
// ----------------------------------------------------------------------------
// crt_pair_search
// smallest day k with k = x in a cycle of M and k = y in a cycle of N
// ----------------------------------------------------------------------------
// One item is taken at a time; ready is high only while the block is idle. The
// larger modulus is the base, its target the start day. A bit-serial divider
// forms the gcd by Euclid, the number of candidates big/gcd, and the residues
// of the step and the start day modulo the smaller modulus; the search then
// tests one candidate per cycle. A zero modulus skips the divides and the
// search and goes straight to the finish. The result waits in an output
// register, so the next item can be taken before it is collected.
// ----------------------------------------------------------------------------
module crt_pair_search #(
  parameter int MOD_WIDTH = 16
) (
  input  logic clk,
  input  logic rst,
  crt_in_if.sink    in_ch,
  crt_out_if.source out_ch
);

  localparam int MW = (MOD_WIDTH >= crt_pkg::VAL_W) ? crt_pkg::VAL_W : MOD_WIDTH;
  localparam logic [crt_pkg::VAL_W:0] MASK_WIDE = ({{crt_pkg::VAL_W{1'b0}}, 1'b1} << MW) - 1'b1;
  localparam crt_pkg::val_t MASK = MASK_WIDE[crt_pkg::VAL_W-1:0];

  crt_pkg::state_t state, state_next;

  crt_pkg::val_t mm, nn, tx, ty;
  crt_pkg::val_t big, sml, tbig, tsml;
  crt_pkg::val_t ga, gb, span, bm, r, i;
  crt_pkg::day_t k;
  logic          hit;
  logic          div_go;
  logic          out_valid;
  logic          out_found;
  crt_pkg::day_t out_day;

  crt_pkg::div_req_t div_req;
  crt_pkg::div_rsp_t div_rsp;

  logic                    accept;
  logic                    zero_mod;
  logic                    match;
  logic                    last;
  logic                    load_out;
  logic [crt_pkg::VAL_W:0] rsum;
  crt_pkg::val_t           r_next;

  crt_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    mm       = in_ch.modulus_m & MASK;
    nn       = in_ch.modulus_n & MASK;
    tx       = in_ch.target_x & MASK;
    ty       = in_ch.target_y & MASK;
    zero_mod = (mm == '0) || (nn == '0);
    accept   = in_ch.valid && in_ch.ready;
    match    = (r == tsml) || (r == '0 && sml == tsml);
    last     = (i == span);
    rsum     = {1'b0, r} + {1'b0, bm};
    r_next   = (rsum >= {1'b0, sml}) ? crt_pkg::VAL_W'(rsum - {1'b0, sml})
                                      : rsum[crt_pkg::VAL_W-1:0];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      crt_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = zero_mod ? crt_pkg::ST_FINISH : crt_pkg::ST_GCD;
        end
      end
      crt_pkg::ST_GCD: begin
        if (div_rsp.done && div_rsp.remainder == '0) begin
          state_next = crt_pkg::ST_SPAN;
        end
      end
      crt_pkg::ST_SPAN: begin
        if (div_rsp.done) begin
          state_next = crt_pkg::ST_BMOD;
        end
      end
      crt_pkg::ST_BMOD: begin
        if (div_rsp.done) begin
          state_next = crt_pkg::ST_TMOD;
        end
      end
      crt_pkg::ST_TMOD: begin
        if (div_rsp.done) begin
          state_next = crt_pkg::ST_SEARCH;
        end
      end
      crt_pkg::ST_SEARCH: begin
        if (last || match) begin
          state_next = crt_pkg::ST_FINISH;
        end
      end
      crt_pkg::ST_FINISH: begin
        if (load_out) begin
          state_next = crt_pkg::ST_IDLE;
        end
      end
      default: state_next = crt_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ch.ready      = 1'b0;
    load_out         = 1'b0;
    div_req.start    = div_go;
    div_req.dividend = big;
    div_req.divisor  = sml;
    case (state)
      crt_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
      end
      crt_pkg::ST_GCD: begin
        div_req.dividend = ga;
        div_req.divisor  = gb;
      end
      crt_pkg::ST_SPAN: begin
        div_req.dividend = big;
        div_req.divisor  = ga;
      end
      crt_pkg::ST_BMOD: begin
        div_req.dividend = big;
        div_req.divisor  = sml;
      end
      crt_pkg::ST_TMOD: begin
        div_req.dividend = tbig;
        div_req.divisor  = sml;
      end
      crt_pkg::ST_SEARCH: begin
        div_req.start = 1'b0;
      end
      crt_pkg::ST_FINISH: begin
        load_out = !out_valid || out_ch.ready;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= crt_pkg::ST_IDLE;
      div_go    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      div_go <= 1'b0;
      if (state == crt_pkg::ST_IDLE && accept && !zero_mod) begin
        div_go <= 1'b1;
      end
      if (div_rsp.done && state_next != crt_pkg::ST_SEARCH) begin
        div_go <= 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      crt_pkg::ST_IDLE: begin
        hit <= 1'b0;
        if (mm > nn) begin
          big <= mm; sml <= nn; tbig <= tx; tsml <= ty;
          ga  <= mm; gb  <= nn;
        end else begin
          big <= nn; sml <= mm; tbig <= ty; tsml <= tx;
          ga  <= nn; gb  <= mm;
        end
      end
      crt_pkg::ST_GCD: begin
        if (div_rsp.done) begin
          ga <= gb;
          gb <= div_rsp.remainder;
        end
      end
      crt_pkg::ST_SPAN: begin
        if (div_rsp.done) begin
          span <= div_rsp.quotient;
        end
      end
      crt_pkg::ST_BMOD: begin
        if (div_rsp.done) begin
          bm <= div_rsp.remainder;
        end
      end
      crt_pkg::ST_TMOD: begin
        if (div_rsp.done) begin
          r <= div_rsp.remainder;
          k <= crt_pkg::DAY_W'(tbig);
          i <= '0;
        end
      end
      crt_pkg::ST_SEARCH: begin
        if (!last && match) begin
          hit <= 1'b1;
        end else if (!last) begin
          r <= r_next;
          k <= k + crt_pkg::DAY_W'(big);
          i <= i + 1'b1;
        end
      end
      crt_pkg::ST_FINISH: begin
        if (load_out) begin
          out_found <= hit;
          out_day   <= hit ? k : '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.found      = out_found;
  assign out_ch.day_number = out_day;

endmodule
